@@ hdl/packet_loss_rate_window_macros.svh @@
// Assertion macros for the packet loss rate window block.
// Used by the top level only; relies on i_clk and i_rst_n in the including scope.
`ifndef PACKET_LOSS_RATE_WINDOW_MACROS_SVH
`define PACKET_LOSS_RATE_WINDOW_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PLRW_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PLRW_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

@@ hdl/plrw_pkg.sv @@
// Shared widths, constants and types for the packet loss rate window block.
// No dependencies; imported by plrw_ctrl, plrw_dp and packet_loss_rate_window.
`default_nettype none

package plrw_pkg;

    localparam int SEQ_W      = 16;
    localparam int RATE_W     = 16;
    localparam int CNT_W      = 32;
    localparam int WIN_W      = 16;
    localparam int CYC_W      = SEQ_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CYC_W;
    localparam int MAX_STEPS  = (SEQ_W > RATE_W) ? SEQ_W : RATE_W;
    localparam int STEP_W     = $clog2(MAX_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(1);

    localparam logic [CYC_W-1:0] CYC_MAX   = CYC_W'(1) << SEQ_W;
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(100);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_UPD,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic update;
        logic load_div;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic close;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ hdl/plrw_ctrl.sv @@
// Controller state machine for the packet loss rate window block.
// Depends on plrw_pkg; drives commands to plrw_dp and reads its status.
`default_nettype none

module plrw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire plrw_pkg::t_status i_status,
    output plrw_pkg::t_cmd         o_cmd,
    output logic                   o_in_stall
);
    import plrw_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step_cnt, n_step_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step_cnt   = '0;
                    if (!i_status.ignore) begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt + STEP_W'(1);
                if (r_step_cnt == STEP_W'(SEQ_W - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = i_status.close ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                o_cmd.load_div = 1'b1;
                n_step_cnt     = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt + STEP_W'(1);
                if (r_step_cnt == STEP_W'(RATE_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Wait until the output register is empty or being emptied.
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/plrw_dp.sv @@
// Datapath of the packet loss rate window block: configuration, window
// counters, a shared shift-subtract divider and the output register. Uses plrw_pkg.
`default_nettype none

module plrw_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [plrw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [plrw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [plrw_pkg::SEQ_W-1:0]         i_seq_number,
    input  wire logic                               i_out_stall,
    input  wire plrw_pkg::t_cmd                     i_cmd,
    output plrw_pkg::t_status                       o_status,
    output logic                                    o_out_valid,
    output logic [plrw_pkg::RATE_W-1:0]             o_loss_rate,
    output logic [plrw_pkg::CNT_W-1:0]              o_lost_count,
    output logic [plrw_pkg::CNT_W-1:0]              o_sent_count
);
    import plrw_pkg::*;

    logic [CYC_W-1:0]  r_cycle_size;
    logic [WIN_W-1:0]  r_window_size;
    logic [SEQ_W-1:0]  r_prev;
    logic [WIN_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_lost;
    logic [CNT_W-1:0]  r_sent;
    logic              r_out_valid;

    logic [SEQ_W-1:0]  r_val;
    logic [CNT_W-1:0]  r_rem;
    logic [SEQ_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dvsr;
    logic [RATE_W-1:0] r_quo;
    logic              r_zero;
    logic              r_sat;
    logic [CNT_W-1:0]  r_win_lost;
    logic [CNT_W-1:0]  r_win_sent;
    logic [RATE_W-1:0] r_out_rate;
    logic [CNT_W-1:0]  r_out_lost;
    logic [CNT_W-1:0]  r_out_sent;

    logic [CYC_W-1:0]  cyc_eff;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [SEQ_W-1:0]  prev_mod;
    logic [CYC_W-1:0]  gap;
    logic [CNT_W:0]    sum_sent;
    logic [CNT_W:0]    sum_lost;
    logic [CNT_W-1:0]  n_sent;
    logic [CNT_W-1:0]  n_lost;
    logic [WIN_W-1:0]  n_fill;
    logic [RATE_W-1:0] n_rate;

    assign cyc_eff = (r_cycle_size > CYC_MAX) ? CYC_MAX : r_cycle_size;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {r_rem, r_dvd[SEQ_W-1]};
    assign ge      = shifted >= {1'b0, r_dvsr};
    assign diff    = shifted - {1'b0, r_dvsr};

    // The divider leaves previous_seq modulo the cycle size in its remainder.
    assign prev_mod = r_rem[SEQ_W-1:0];
    always_comb begin
        gap = {1'b0, r_val} - {1'b0, prev_mod};
        if (r_val < prev_mod) begin
            gap = gap + cyc_eff;
        end
    end

    assign sum_sent = {1'b0, r_sent} + (CNT_W + 1)'(gap);
    assign sum_lost = {1'b0, r_lost} + (CNT_W + 1)'(gap - CYC_W'(1));
    assign n_sent   = sum_sent[CNT_W] ? '1 : sum_sent[CNT_W-1:0];
    assign n_lost   = sum_lost[CNT_W] ? '1 : sum_lost[CNT_W-1:0];
    assign n_fill   = r_fill + WIN_W'(1);

    always_comb begin
        if (r_zero) begin
            n_rate = '0;
        end else if (r_sat) begin
            n_rate = '1;
        end else begin
            n_rate = r_quo;
        end
    end

    assign o_status.ignore   = {1'b0, i_seq_number} >= cyc_eff;
    assign o_status.close    = n_fill >= r_window_size;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_size  <= CYC_MAX;
            r_window_size <= WIN_RESET;
            r_prev        <= '0;
            r_fill        <= '0;
            r_lost        <= '0;
            r_sent        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CYCLE_SIZE:  r_cycle_size  <= i_cfg_data;
                    REG_WINDOW_SIZE: r_window_size <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_prev <= r_val;
                r_fill <= n_fill;
                if (gap != '0) begin
                    r_sent <= n_sent;
                    r_lost <= n_lost;
                end
            end
            if (i_cmd.load_div) begin
                r_fill <= '0;
                r_lost <= '0;
                r_sent <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val  <= i_seq_number;
            r_rem  <= '0;
            r_dvd  <= r_prev;
            r_dvsr <= CNT_W'(cyc_eff);
        end
        if (i_cmd.step) begin
            r_rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[RATE_W-2:0], ge};
        end
        if (i_cmd.load_div) begin
            // A quotient of one or more does not fit the fraction and saturates.
            r_rem      <= r_lost;
            r_dvd      <= '0;
            r_dvsr     <= r_sent;
            r_zero     <= (r_sent == '0);
            r_sat      <= (r_lost >= r_sent);
            r_win_lost <= r_lost;
            r_win_sent <= r_sent;
        end
        if (i_cmd.load_out) begin
            r_out_rate <= n_rate;
            r_out_lost <= r_win_lost;
            r_out_sent <= r_win_sent;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_loss_rate  = r_out_rate;
    assign o_lost_count = r_out_lost;
    assign o_sent_count = r_out_sent;

endmodule

`default_nettype wire

@@ hdl/packet_loss_rate_window.sv @@
// Top level of the packet loss rate window block: controller plus datapath.
// Depends on plrw_pkg, plrw_ctrl, plrw_dp and packet_loss_rate_window_macros.svh.
//
//   Channel   Handshake                 Payload
//   input     i_in_valid / o_in_stall   i_seq_number
//   output    o_out_valid / i_out_stall o_loss_rate, o_lost_count, o_sent_count
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An ignored sequence number is accepted without leaving the idle state. Any other
// goes through the accept, 16 steps of the shared shift-subtract divider for the
// modulo of the previous number, and an update. A closing window adds a load,
// 16 divider steps for the rate, and the hand-off to the output register.
// If the output register still holds an earlier result at the hand-off, the
// controller waits there and the input stays stalled until that result is taken.
// Reset is synchronous and active low; configuration is always ready.
`default_nettype none
`include "packet_loss_rate_window_macros.svh"

module packet_loss_rate_window (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [plrw_pkg::SEQ_W-1:0]         i_seq_number,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [plrw_pkg::RATE_W-1:0]             o_loss_rate,
    output logic [plrw_pkg::CNT_W-1:0]              o_lost_count,
    output logic [plrw_pkg::CNT_W-1:0]              o_sent_count,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [plrw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [plrw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import plrw_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_counted;

    assign o_cfg_ready = 1'b1;

    // A transaction on the input that is not ignored starts the divider.
    assign in_counted = i_in_valid && !o_in_stall && !status.ignore;

    plrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    plrw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_seq_number (i_seq_number),
        .i_out_stall  (i_out_stall),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_loss_rate  (o_loss_rate),
        .o_lost_count (o_lost_count),
        .o_sent_count (o_sent_count)
    );

    `PLRW_ASSERT_NEXT(a_busy_after_accept, in_counted, o_in_stall, "no stall after a number")
    `PLRW_ASSERT_NOW(a_load_into_free_slot, cmd.load_out, status.out_free, "load over a result")
    `PLRW_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, o_out_valid, "loaded result not shown")
    `PLRW_ASSERT_NOW(a_lost_within_sent, o_out_valid, o_lost_count <= o_sent_count, "lost > sent")
    `PLRW_ASSERT_NOW(a_rate_needs_sent, o_out_valid && (o_loss_rate != '0), o_sent_count != '0, "rate, no sent")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for packet_loss_rate_window: directed corner cases, then random
// sequence-number walks under several idle and stall mixes, checked by an in-bench model.
// Depends on plrw_pkg and the packet_loss_rate_window RTL only.

module testbench;
    import plrw_pkg::*;

    localparam int CLK_HALF_NS = 4;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS = 420;
    localparam int MAX_REPORTS = 10;
    localparam longint TIMEOUT_NS = 64'd10_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
    localparam logic [63:0] RATE_MAX = (64'd1 << RATE_W) - 1;

    typedef enum logic [1:0] {
        JOB_SEQ,
        JOB_WRITE,
        JOB_DRAIN
    } job_kind_e;

    typedef struct {
        job_kind_e             kind;
        logic [SEQ_W-1:0]      seq;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int                    idle_pct;
        int                    stall_pct;
    } job_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [CNT_W-1:0]  lost;
        logic [CNT_W-1:0]  sent;
    } window_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic [SEQ_W-1:0]      i_seq_number;
    logic                  i_out_stall;
    logic                  i_cfg_valid;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    wire                   o_in_stall;
    wire                   o_out_valid;
    wire  [RATE_W-1:0]     o_loss_rate;
    wire  [CNT_W-1:0]      o_lost_count;
    wire  [CNT_W-1:0]      o_sent_count;
    wire                   o_cfg_ready;

    // Model of the block: configuration and window state.
    logic [CYC_W-1:0] model_cycle;
    logic [WIN_W-1:0] model_window;
    logic [SEQ_W-1:0] model_prev;
    logic [WIN_W-1:0] model_fill;
    logic [CNT_W-1:0] model_lost;
    logic [CNT_W-1:0] model_sent;

    job_t           job_q[$];
    window_result_t window_results_q[$];
    int             mismatches;
    int             quiet_cycles;
    int             recv_stall_pct;
    logic           in_taken;
    logic           cfg_taken;

    // Generator view of the configuration, used to shape the sequence walks.
    int gen_eff;
    int gen_last;
    int gen_accepted;
    int gen_idle_pct;
    int gen_stall_pct;

    packet_loss_rate_window uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_seq_number (i_seq_number),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_loss_rate  (o_loss_rate),
        .o_lost_count (o_lost_count),
        .o_sent_count (o_sent_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // Accounts one received sequence number; returns 1 when it closes the window.
    function automatic bit account_packet(input logic [SEQ_W-1:0] seq,
                                          output window_result_t res);
        logic [CYC_W-1:0] eff;
        logic [CYC_W-1:0] seq_x;
        logic [CYC_W-1:0] prev_m;
        logic [CYC_W-1:0] gap;
        logic [63:0]      rate;
        res = '0;
        eff = (model_cycle > CYC_MAX) ? CYC_MAX : model_cycle;
        seq_x = CYC_W'(seq);
        if (seq_x >= eff) return 1'b0;
        // A previous number left over from a larger cycle is folded into the new one.
        prev_m = CYC_W'(model_prev) % eff;
        gap = (seq_x >= prev_m) ? seq_x - prev_m : eff + seq_x - prev_m;
        model_fill = model_fill + 1'b1;
        if (gap != 0) begin
            model_sent = sat_add32(model_sent, CNT_W'(gap));
            model_lost = sat_add32(model_lost, CNT_W'(gap - 1'b1));
        end
        model_prev = seq;
        if (model_fill < model_window) return 1'b0;
        rate = '0;
        if (model_sent != 0) begin
            rate = (64'(model_lost) << RATE_W) / 64'(model_sent);
            if (rate > RATE_MAX) rate = RATE_MAX;
        end
        res.rate = rate[RATE_W-1:0];
        res.lost = model_lost;
        res.sent = model_sent;
        model_fill = '0;
        model_lost = '0;
        model_sent = '0;
        return 1'b1;
    endfunction

    task automatic push_job(input job_kind_e kind, input int seq, input int idx, input int data);
        job_t j;
        j.kind = kind;
        j.seq = SEQ_W'(seq);
        j.idx = CFG_IDX_W'(idx);
        j.data = CFG_DATA_W'(data);
        j.idle_pct = gen_idle_pct;
        j.stall_pct = gen_stall_pct;
        job_q.push_back(j);
        if (kind == JOB_SEQ && seq < gen_eff) begin
            gen_accepted++;
            gen_last = seq;
        end
        if (kind == JOB_WRITE && j.idx == REG_CYCLE_SIZE) begin
            gen_eff = (data > int'(CYC_MAX)) ? int'(CYC_MAX) : data;
        end
    endtask

    task automatic push_seq(input int seq);
        push_job(JOB_SEQ, seq, 0, 0);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        push_job(JOB_WRITE, 0, int'(idx), data);
    endtask

    // Mostly in-order walks with small losses and repeats; a few jumps and stray numbers.
    task automatic random_phase(input int idle_pct, input int stall_pct);
        int start;
        int cyc;
        int win;
        int n;
        int r;
        int cur;
        int step;
        gen_idle_pct = idle_pct;
        gen_stall_pct = stall_pct;
        start = gen_accepted;
        push_job(JOB_DRAIN, 0, 0, 0);
        while (gen_accepted - start < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 50) cyc = $urandom_range(65536, 2);
            else if (r < 70) cyc = $urandom_range(40, 2);
            else if (r < 80) cyc = int'(CYC_MAX);
            else if (r < 88) cyc = $urandom_range(131071, 65537);
            else if (r < 93) cyc = 1;
            else if (r < 96) cyc = 0;
            else cyc = 3;
            r = $urandom_range(99);
            if (r < 60) win = $urandom_range(10, 1);
            else if (r < 80) win = $urandom_range(40, 11);
            else if (r < 90) win = 0;
            else win = $urandom_range(80, 41);
            win = win | ($urandom_range(1) << WIN_W);
            push_write(REG_CYCLE_SIZE, cyc);
            push_write(REG_WINDOW_SIZE, win);
            if ($urandom_range(9) == 0) begin
                push_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                           $urandom_range(131071));
            end
            n = (cyc == 0) ? 8 : $urandom_range(80, 20);
            cur = (gen_eff > 0) ? gen_last % gen_eff : 0;
            repeat (n) begin
                r = $urandom_range(99);
                if (gen_eff == 0 || r >= 97) begin
                    push_seq($urandom_range(65535));
                end else begin
                    if (r < 75) step = 1;
                    else if (r < 83) step = 0;
                    else if (r < 93) step = $urandom_range(6, 2);
                    else step = $urandom_range(gen_eff - 1);
                    cur = (cur + step) % gen_eff;
                    push_seq(cur);
                end
                if ($urandom_range(149) == 0) push_job(JOB_DRAIN, 0, 0, 0);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench: done, errors");
        $finish;
    end

    // Sender, configuration writer and receiver stall, all driven on the falling edge.
    always @(negedge i_clk) begin
        job_t             job;
        logic             busy;
        logic             drive_in;
        logic             drive_cfg;
        logic [SEQ_W-1:0] next_seq;
        if (i_rst_n) begin
            i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
            busy = (i_in_valid && !in_taken) || (i_cfg_valid && !cfg_taken);
            if (!busy) begin
                if (!i_in_valid && !i_cfg_valid && window_results_q.size() == 0)
                    quiet_cycles++;
                else
                    quiet_cycles = 0;
                drive_in = 1'b0;
                drive_cfg = 1'b0;
                next_seq = SEQ_W'($urandom);
                if (job_q.size() != 0) begin
                    job = job_q[0];
                    case (job.kind)
                        JOB_SEQ: begin
                            if ($urandom_range(99) >= job.idle_pct) begin
                                void'(job_q.pop_front());
                                recv_stall_pct = job.stall_pct;
                                drive_in = 1'b1;
                                next_seq = job.seq;
                            end
                        end
                        default: begin
                            // Writes and pauses wait until the block has been quiet a while.
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                void'(job_q.pop_front());
                                recv_stall_pct = job.stall_pct;
                                if (job.kind == JOB_WRITE) begin
                                    drive_cfg = 1'b1;
                                    i_cfg_index <= job.idx;
                                    i_cfg_data <= job.data;
                                end
                            end
                        end
                    endcase
                end
                i_in_valid <= drive_in;
                i_cfg_valid <= drive_cfg;
                i_seq_number <= next_seq;
            end
        end
    end

    // Every transaction is observed on the rising edge: results are checked, inputs
    // and register writes are fed to the model.
    always @(posedge i_clk) begin
        window_result_t got;
        window_result_t want;
        window_result_t fresh;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            cfg_taken <= 1'b0;
            model_cycle = CYC_MAX;
            model_window = WIN_RESET;
            model_prev = '0;
            model_fill = '0;
            model_lost = '0;
            model_sent = '0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            if (o_out_valid && !i_out_stall) begin
                got.rate = o_loss_rate;
                got.lost = o_lost_count;
                got.sent = o_sent_count;
                if (window_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected window result: rate %0d lost %0d sent %0d",
                                 got.rate, got.lost, got.sent);
                end else begin
                    want = window_results_q.pop_front();
                    if (got.rate !== want.rate || got.lost !== want.lost
                            || got.sent !== want.sent) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("window result mismatch: rate exp %0d got %0d, %s",
                                     want.rate, got.rate, "lost and sent follow");
                            $display("    lost exp %0d got %0d, sent exp %0d got %0d",
                                     want.lost, got.lost, want.sent, got.sent);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (account_packet(i_seq_number, fresh)) window_results_q.push_back(fresh);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_CYCLE_SIZE)
                    model_cycle = i_cfg_data;
                else if (i_cfg_index == REG_WINDOW_SIZE)
                    model_window = i_cfg_data[WIN_W-1:0];
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_seq_number = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_CYCLE_SIZE;
        i_cfg_data = '0;
        mismatches = 0;
        quiet_cycles = 0;
        recv_stall_pct = 0;
        gen_eff = int'(CYC_MAX);
        gen_last = 0;
        gen_accepted = 0;
        gen_idle_pct = 0;
        gen_stall_pct = 0;

        // Directed corners: the first packet repeats the reset value, so nothing is sent.
        push_write(REG_WINDOW_SIZE, 1);
        push_seq(0);
        push_seq(65535);
        push_seq(0);
        push_seq(0);
        push_seq(32768);
        push_seq(1);
        // A zero window closes on every packet.
        push_write(REG_WINDOW_SIZE, 0);
        push_seq(5);
        push_seq(6);
        // Cycle sizes past the sequence range behave as the full range.
        push_write(REG_CYCLE_SIZE, 131071);
        push_seq(65535);
        push_seq(3);
        // A cycle of one accepts only zero; a cycle of zero accepts nothing.
        push_write(REG_CYCLE_SIZE, 1);
        push_seq(0);
        push_seq(0);
        push_seq(1);
        push_seq(65535);
        push_write(REG_CYCLE_SIZE, 0);
        push_seq(0);
        push_seq(7);
        // Shrinking the cycle leaves a stale previous number; then the window is lowered.
        push_write(REG_CYCLE_SIZE, int'(CYC_MAX));
        push_write(REG_WINDOW_SIZE, 65535);
        push_seq(50000);
        push_seq(50010);
        push_write(REG_CYCLE_SIZE, 1000);
        push_write(REG_WINDOW_SIZE, 'h1_0002);
        push_seq(5);
        push_write(REG_SPARE_LO, 'h1_FFFF);
        push_write(REG_SPARE_HI, 0);
        push_write(REG_CYCLE_SIZE, 2);
        push_write(REG_WINDOW_SIZE, 3);
        push_seq(0);
        push_seq(1);
        push_seq(0);
        push_seq(1);

        random_phase(0, 0);
        random_phase(59, 0);
        random_phase(0, 59);
        random_phase(20, 20);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || i_in_valid || i_cfg_valid || window_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (window_results_q.size() != 0) begin
            mismatches++;
            $display("%0d window results never arrived", window_results_q.size());
        end
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/plrw_pkg.sv
hdl/plrw_ctrl.sv
hdl/plrw_dp.sv
hdl/packet_loss_rate_window.sv
tb/testbench.sv
